/* rtl/windowed_utilization_rate_monitor_macros.svh */
// Assertion macros used by the controller of the windowed utilization rate monitor.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef WINDOWED_UTILIZATION_RATE_MONITOR_MACROS_SVH
`define WINDOWED_UTILIZATION_RATE_MONITOR_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define WURM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("wurm assertion failed");

// Check a property on every rising clock edge, reset included.
`define WURM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("wurm assertion failed");

`else

`define WURM_ASSERT(lbl, clk, rstn, prop)
`define WURM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/wurm_pkg.sv */
// Shared types and constants of the windowed utilization rate monitor.
// Used by the divider, datapath, controller and top level; depends on nothing.
package wurm_pkg;

  // Input action codes.
  typedef enum logic [2:0] {
    ACT_PASS   = 3'd0,
    ACT_BUSY   = 3'd1,
    ACT_LINK   = 3'd2,
    ACT_FRAMES = 3'd3,
    ACT_SVC    = 3'd4
  } act_e;

  // Quantity being worked on during a window close.
  typedef enum logic [2:0] {
    OP_BUSY   = 3'd0,
    OP_LINK   = 3'd1,
    OP_FRAME  = 3'd2,
    OP_PASS   = 3'd3,
    OP_CALLS  = 3'd4,
    OP_WORKED = 3'd5
  } op_e;

  // Divider job kinds.
  typedef enum logic [1:0] {
    DIV_FULL = 2'd0,
    DIV_FRAC = 2'd1,
    DIV_PCT  = 2'd2
  } div_e;

  localparam int unsigned DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] STEPS_FULL = 7'd64;
  localparam logic [DIV_CNT_W-1:0] STEPS_FRAC = 7'd20;
  localparam logic [DIV_CNT_W-1:0] STEPS_PCT  = 7'd7;

  localparam logic [31:0] SCALE_US   = 32'd1000000;
  localparam logic [6:0]  PCT_SCALE  = 7'd100;
  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [31:0] WLEN_RESET = 32'd1000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_en;
    logic close;
    logic pct_mul;
    logic rate_mul;
    logic div_start;
    div_e div_kind;
    logic store;
    logic load;
    logic last;
    logic clear;
    op_e  op;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic closes;
    logic div_busy;
    logic ge;
  } dp_sts_t;

endpackage

/* rtl/windowed_utilization_rate_monitor.sv */
// An item that closes no window is taken back to back while the controller is idle. A
// window close holds off input until its records are out, output stalls included, and is
// paced by the shared one-bit-per-cycle divider: each rate needs a 64-step and a 20-step
// division, each percent a 7-step one unless it clamps at 100.
// Reset (rst_ni low, asynchronous) clears all sums, counts and the CPU peak, and
// sets the window length to 1000000 us; no clearing pass is needed.
module windowed_utilization_rate_monitor #(
  parameter int unsigned SERVICE_COUNT = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        window_length_we_i,
  input  logic [31:0] window_length_us_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] now_us_i,
  input  logic [31:0] amount_i,
  input  logic [2:0]  service_index_i,
  input  logic        did_work_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        record_kind_o,
  output logic [2:0]  record_service_o,
  output logic [6:0]  cpu_util_o,
  output logic [6:0]  cpu_util_peak_o,
  output logic [6:0]  link_percent_o,
  output logic [31:0] frames_per_second_o,
  output logic [31:0] passes_per_second_o,
  output logic [31:0] calls_per_second_o,
  output logic [31:0] worked_per_second_o,
  output logic        last_o
);

  localparam int unsigned SVC_W = (SERVICE_COUNT > 1) ? $clog2(SERVICE_COUNT) : 1;

  wurm_pkg::dp_cmd_t cmd;
  wurm_pkg::dp_sts_t sts;
  logic [SVC_W-1:0]  svc;

  wurm_ctrl #(
    .SERVICE_COUNT (SERVICE_COUNT),
    .SVC_W         (SVC_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .svc_o       (svc)
  );

  wurm_dp #(
    .SERVICE_COUNT (SERVICE_COUNT),
    .SVC_W         (SVC_W)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .window_length_we_i  (window_length_we_i),
    .window_length_us_i  (window_length_us_i),
    .action_i            (action_i),
    .now_us_i            (now_us_i),
    .amount_i            (amount_i),
    .service_index_i     (service_index_i),
    .did_work_i          (did_work_i),
    .cmd_i               (cmd),
    .svc_i               (svc),
    .sts_o               (sts),
    .record_kind_o       (record_kind_o),
    .record_service_o    (record_service_o),
    .cpu_util_o          (cpu_util_o),
    .cpu_util_peak_o     (cpu_util_peak_o),
    .link_percent_o      (link_percent_o),
    .frames_per_second_o (frames_per_second_o),
    .passes_per_second_o (passes_per_second_o),
    .calls_per_second_o  (calls_per_second_o),
    .worked_per_second_o (worked_per_second_o),
    .last_o              (last_o)
  );

endmodule

/* rtl/wurm_div.sv */
// Restoring divider, one quotient bit per cycle, for the rate monitor.
// Depends on wurm_pkg for the step counter width.
module wurm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wurm_pkg::DIV_CNT_W-1:0] steps_i,
  input  logic [31:0]                    rem_i,
  input  logic [63:0]                    num_i,
  input  logic [31:0]                    divisor_i,
  output logic                           busy_o,
  output logic [63:0]                    quo_o,
  output logic [31:0]                    rem_o
);

  logic [wurm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [32:0] part;
  logic [33:0] diff;
  logic        take;

  // One shift and trial subtract; quotient bits enter at the low end.
  always_comb begin
    part  = {rem_q, num_q[63]};
    diff  = {1'b0, part} - {2'b00, divisor_i};
    take  = ~diff[33];
    cnt_d = cnt_q;
    rem_d = rem_q;
    num_d = num_q;
    if (start_i) begin
      cnt_d = steps_i;
      rem_d = rem_i;
      num_d = num_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = take ? diff[31:0] : part[31:0];
      num_d = {num_q[62:0], take};
    end
  end

  // Step counter is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Partial remainder and dividend/quotient shifter.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/wurm_dp.sv */
// Datapath of the rate monitor: accumulators, multipliers, divider, output register.
// Depends on wurm_pkg and instantiates wurm_div.
module wurm_dp #(
  parameter int unsigned SERVICE_COUNT = 6,
  parameter int unsigned SVC_W = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 window_length_we_i,
  input  logic [31:0]          window_length_us_i,
  input  logic [2:0]           action_i,
  input  logic [31:0]          now_us_i,
  input  logic [31:0]          amount_i,
  input  logic [2:0]           service_index_i,
  input  logic                 did_work_i,
  input  wurm_pkg::dp_cmd_t    cmd_i,
  input  logic [SVC_W-1:0]     svc_i,
  output wurm_pkg::dp_sts_t    sts_o,
  output logic                 record_kind_o,
  output logic [2:0]           record_service_o,
  output logic [6:0]           cpu_util_o,
  output logic [6:0]           cpu_util_peak_o,
  output logic [6:0]           link_percent_o,
  output logic [31:0]          frames_per_second_o,
  output logic [31:0]          passes_per_second_o,
  output logic [31:0]          calls_per_second_o,
  output logic [31:0]          worked_per_second_o,
  output logic                 last_o
);

  // Window state and accumulators.
  logic [31:0] wlen_q;
  logic [31:0] start_q;
  logic [31:0] busy_q;
  logic [31:0] link_q;
  logic [63:0] frame_q;
  logic [31:0] pass_q;
  logic [6:0]  peak_q;
  logic [31:0] calls_q  [SERVICE_COUNT];
  logic [31:0] worked_q [SERVICE_COUNT];

  // Close-time working registers.
  logic [31:0] elap_q;
  logic [38:0] x_q;
  logic        ge_q;
  logic [51:0] prod_q;
  logic [31:0] qm_q;
  logic [6:0]  cpu_r_q;
  logic [6:0]  link_r_q;
  logic [31:0] fps_r_q;
  logic [31:0] pps_r_q;
  logic [31:0] calls_r_q;
  logic [31:0] worked_r_q;

  logic [31:0] elapsed;
  logic [31:0] len;
  logic        svc_ok;
  logic [SVC_W-1:0] in_idx;
  logic [31:0] sum32;
  logic [63:0] n64;
  logic [6:0]  pct_val;
  logic [31:0] rate_val;

  logic                           div_busy;
  logic [63:0]                    div_quo;
  logic [31:0]                    div_rem;
  logic [wurm_pkg::DIV_CNT_W-1:0] div_steps;
  logic [31:0]                    div_rem_init;
  logic [63:0]                    div_num_init;

  // Window close test on the offered beat; a zero length acts as one.
  always_comb begin
    elapsed = now_us_i - start_q;
    len     = (wlen_q == '0) ? 32'd1 : wlen_q;
    svc_ok  = (32'(service_index_i) < 32'(SERVICE_COUNT));
    in_idx  = SVC_W'(service_index_i);
  end

  assign sts_o.closes   = (action_i == wurm_pkg::ACT_PASS) && (elapsed >= len);
  assign sts_o.div_busy = div_busy;
  assign sts_o.ge       = ge_q;

  // Window length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= wurm_pkg::WLEN_RESET;
    end else if (window_length_we_i) begin
      wlen_q <= window_length_us_i;
    end
  end

  // Global accumulators, cleared after the last record of a close.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      busy_q  <= '0;
      link_q  <= '0;
      frame_q <= '0;
      pass_q  <= '0;
    end else if (cmd_i.clear) begin
      busy_q  <= '0;
      link_q  <= '0;
      frame_q <= '0;
      pass_q  <= '0;
    end else if (cmd_i.acc_en) begin
      unique case (action_i)
        wurm_pkg::ACT_PASS:   pass_q  <= pass_q + 32'd1;
        wurm_pkg::ACT_BUSY:   busy_q  <= busy_q + amount_i;
        wurm_pkg::ACT_LINK:   link_q  <= link_q + amount_i;
        wurm_pkg::ACT_FRAMES: frame_q <= frame_q + {32'd0, amount_i};
        default: ;
      endcase
      if (cmd_i.close) begin
        start_q <= now_us_i;
      end
    end
  end

  // Per-service counters, one lane per service.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SERVICE_COUNT; k++) begin
        calls_q[k]  <= '0;
        worked_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < SERVICE_COUNT; k++) begin
        if (cmd_i.clear) begin
          calls_q[k]  <= '0;
          worked_q[k] <= '0;
        end else if (cmd_i.acc_en && (action_i == wurm_pkg::ACT_SVC) && svc_ok &&
                     (in_idx == SVC_W'(k))) begin
          calls_q[k] <= calls_q[k] + 32'd1;
          if (did_work_i) begin
            worked_q[k] <= worked_q[k] + 32'd1;
          end
        end
      end
    end
  end

  // Operand selection for the quantity being worked on.
  always_comb begin
    sum32 = (cmd_i.op == wurm_pkg::OP_LINK) ? link_q : busy_q;
    unique case (cmd_i.op)
      wurm_pkg::OP_FRAME:  n64 = frame_q;
      wurm_pkg::OP_PASS:   n64 = {32'd0, pass_q};
      wurm_pkg::OP_CALLS:  n64 = {32'd0, calls_q[svc_i]};
      wurm_pkg::OP_WORKED: n64 = {32'd0, worked_q[svc_i]};
      default:             n64 = '0;
    endcase
  end

  // Divider job setup: full quotient, fractional part, or percent.
  always_comb begin
    unique case (cmd_i.div_kind)
      wurm_pkg::DIV_FULL: begin
        div_steps    = wurm_pkg::STEPS_FULL;
        div_rem_init = '0;
        div_num_init = n64;
      end
      wurm_pkg::DIV_FRAC: begin
        div_steps    = wurm_pkg::STEPS_FRAC;
        div_rem_init = prod_q[51:20];
        div_num_init = {prod_q[19:0], 44'd0};
      end
      wurm_pkg::DIV_PCT: begin
        div_steps    = wurm_pkg::STEPS_PCT;
        div_rem_init = x_q[38:7];
        div_num_init = {x_q[6:0], 57'd0};
      end
      default: begin
        div_steps    = '0;
        div_rem_init = '0;
        div_num_init = '0;
      end
    endcase
  end

  wurm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .steps_i   (div_steps),
    .rem_i     (div_rem_init),
    .num_i     (div_num_init),
    .divisor_i (elap_q),
    .busy_o    (div_busy),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  // Results: percent clamps to 100; a rate is whole part times 1e6 plus the fraction.
  always_comb begin
    pct_val  = ge_q ? wurm_pkg::PCT_MAX : div_quo[6:0];
    rate_val = qm_q + {12'd0, div_quo[19:0]};
  end

  // Elapsed time latch and multiplier stages.
  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      elap_q <= elapsed;
    end
    if (cmd_i.pct_mul) begin
      x_q  <= 39'(sum32) * 39'(wurm_pkg::PCT_SCALE);
      ge_q <= (sum32 >= elap_q);
    end
    if (cmd_i.rate_mul) begin
      prod_q <= 52'(div_rem) * 52'(wurm_pkg::SCALE_US);
      qm_q   <= div_quo[31:0] * wurm_pkg::SCALE_US;
    end
  end

  // Result registers for the record being assembled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      unique case (cmd_i.op)
        wurm_pkg::OP_BUSY:   cpu_r_q    <= pct_val;
        wurm_pkg::OP_LINK:   link_r_q   <= pct_val;
        wurm_pkg::OP_FRAME:  fps_r_q    <= rate_val;
        wurm_pkg::OP_PASS:   pps_r_q    <= rate_val;
        wurm_pkg::OP_CALLS:  calls_r_q  <= rate_val;
        wurm_pkg::OP_WORKED: worked_r_q <= rate_val;
        default: ;
      endcase
    end
  end

  // Running CPU peak since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (cmd_i.store && (cmd_i.op == wurm_pkg::OP_BUSY) && (pct_val > peak_q)) begin
      peak_q <= pct_val;
    end
  end

  // Output register: the global record after the pass rate, else a service record.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_o <= cmd_i.last;
      if (cmd_i.op == wurm_pkg::OP_PASS) begin
        record_kind_o       <= 1'b0;
        record_service_o    <= 3'd0;
        cpu_util_o          <= cpu_r_q;
        cpu_util_peak_o     <= peak_q;
        link_percent_o      <= link_r_q;
        frames_per_second_o <= fps_r_q;
        passes_per_second_o <= pps_r_q;
        calls_per_second_o  <= '0;
        worked_per_second_o <= '0;
      end else begin
        record_kind_o       <= 1'b1;
        record_service_o    <= 3'(svc_i);
        cpu_util_o          <= '0;
        cpu_util_peak_o     <= '0;
        link_percent_o      <= '0;
        frames_per_second_o <= '0;
        passes_per_second_o <= '0;
        calls_per_second_o  <= calls_r_q;
        worked_per_second_o <= worked_r_q;
      end
    end
  end

endmodule

/* rtl/wurm_ctrl.sv */
// Controller of the rate monitor: accepts beats and sequences the window close.
// Depends on wurm_pkg and the assertion macro header.
`include "windowed_utilization_rate_monitor_macros.svh"

module wurm_ctrl #(
  parameter int unsigned SERVICE_COUNT = 6,
  parameter int unsigned SVC_W = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wurm_pkg::dp_sts_t sts_i,
  output wurm_pkg::dp_cmd_t cmd_o,
  output logic [SVC_W-1:0]  svc_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_PCT_MUL   = 4'd1;
  localparam logic [3:0] ST_PCT_DIV   = 4'd2;
  localparam logic [3:0] ST_PCT_WAIT  = 4'd3;
  localparam logic [3:0] ST_RATE_DIV1 = 4'd4;
  localparam logic [3:0] ST_RATE_W1   = 4'd5;
  localparam logic [3:0] ST_RATE_MUL  = 4'd6;
  localparam logic [3:0] ST_RATE_DIV2 = 4'd7;
  localparam logic [3:0] ST_RATE_W2   = 4'd8;
  localparam logic [3:0] ST_EMIT      = 4'd9;

  logic [3:0]        state_q, state_d;
  wurm_pkg::op_e     op_q, op_d;
  logic [SVC_W-1:0]  svc_q, svc_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              svc_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign svc_last = (svc_q == SVC_W'(SERVICE_COUNT - 1));

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    svc_d      = svc_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && sts_i.closes) begin
          cmd_o.close = 1'b1;
          op_d        = wurm_pkg::OP_BUSY;
          state_d     = ST_PCT_MUL;
        end
      end
      ST_PCT_MUL: begin
        cmd_o.pct_mul = 1'b1;
        state_d       = ST_PCT_DIV;
      end
      ST_PCT_DIV: begin
        if (sts_i.ge) begin
          cmd_o.store = 1'b1;
          if (op_q == wurm_pkg::OP_BUSY) begin
            op_d    = wurm_pkg::OP_LINK;
            state_d = ST_PCT_MUL;
          end else begin
            op_d    = wurm_pkg::OP_FRAME;
            state_d = ST_RATE_DIV1;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_kind  = wurm_pkg::DIV_PCT;
          state_d         = ST_PCT_WAIT;
        end
      end
      ST_PCT_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.store = 1'b1;
          if (op_q == wurm_pkg::OP_BUSY) begin
            op_d    = wurm_pkg::OP_LINK;
            state_d = ST_PCT_MUL;
          end else begin
            op_d    = wurm_pkg::OP_FRAME;
            state_d = ST_RATE_DIV1;
          end
        end
      end
      ST_RATE_DIV1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind  = wurm_pkg::DIV_FULL;
        state_d         = ST_RATE_W1;
      end
      ST_RATE_W1: begin
        if (!sts_i.div_busy) begin
          state_d = ST_RATE_MUL;
        end
      end
      ST_RATE_MUL: begin
        cmd_o.rate_mul = 1'b1;
        state_d        = ST_RATE_DIV2;
      end
      ST_RATE_DIV2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind  = wurm_pkg::DIV_FRAC;
        state_d         = ST_RATE_W2;
      end
      ST_RATE_W2: begin
        if (!sts_i.div_busy) begin
          cmd_o.store = 1'b1;
          if (op_q == wurm_pkg::OP_FRAME) begin
            op_d    = wurm_pkg::OP_PASS;
            state_d = ST_RATE_DIV1;
          end else if (op_q == wurm_pkg::OP_CALLS) begin
            op_d    = wurm_pkg::OP_WORKED;
            state_d = ST_RATE_DIV1;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.last = (op_q == wurm_pkg::OP_WORKED) && svc_last;
          if (op_q == wurm_pkg::OP_PASS) begin
            op_d    = wurm_pkg::OP_CALLS;
            svc_d   = '0;
            state_d = ST_RATE_DIV1;
          end else if (svc_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            op_d    = wurm_pkg::OP_CALLS;
            svc_d   = svc_q + SVC_W'(1);
            state_d = ST_RATE_DIV1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set when a record is loaded, dropped when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= wurm_pkg::OP_BUSY;
      svc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      svc_q       <= svc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign svc_o       = svc_q;

  // A new division never starts on top of one in flight.
  `WURM_ASSERT(a_div_start_idle, clk_i, rst_ni, cmd_o.div_start |-> !sts_i.div_busy)
  // Results are stored only from a settled divider.
  `WURM_ASSERT(a_store_settled, clk_i, rst_ni, cmd_o.store |-> !sts_i.div_busy)
  // A record is loaded only into a free output slot.
  `WURM_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.load |-> (!out_valid_q || out_ready_i))
  // The service counter stays within the configured services.
  `WURM_ASSERT(a_svc_range, clk_i, rst_ni, 32'(svc_q) < 32'(SERVICE_COUNT))
  // The final record of a close returns the controller to idle.
  `WURM_ASSERT(a_last_idle, clk_i, rst_ni, (cmd_o.load && cmd_o.last) |=> (state_q == ST_IDLE))

endmodule

/* tb/tb_windowed_utilization_rate_monitor.sv */
// Self-checking testbench for the windowed utilization rate monitor.
// Depends on wurm_pkg and the windowed_utilization_rate_monitor RTL only.
// A scoreboard class predicts every window-close record and checks each output beat.
module tb_windowed_utilization_rate_monitor;

  localparam int unsigned SERVICES = 6;
  // Action codes the block has no meaning for.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  // Settling time after the last expected record: a little over one window close.
  localparam int unsigned CLOSE_SETTLE = 1500;
  localparam int unsigned IDLE_SETTLE = 16;

  // One output record as seen on the result channel.
  typedef struct packed {
    logic        kind;
    logic [2:0]  service;
    logic [6:0]  cpu;
    logic [6:0]  cpu_peak;
    logic [6:0]  link;
    logic [31:0] fps;
    logic [31:0] pps;
    logic [31:0] calls;
    logic [31:0] worked;
    logic        is_last;
  } window_record_t;

  // Tracks the monitor's accumulators and queues the records each window close emits.
  class utilization_scoreboard;
    logic [31:0] window_len;
    logic [31:0] window_start;
    logic [31:0] busy_sum;
    logic [31:0] link_sum;
    logic [63:0] frame_sum;
    logic [31:0] pass_count;
    logic [6:0]  cpu_peak;
    logic [31:0] svc_calls [SERVICES];
    logic [31:0] svc_worked [SERVICES];
    window_record_t pending_records [$];
    int unsigned mismatches;
    int unsigned windows_closed;
    int unsigned records_checked;

    function new();
      window_len = wurm_pkg::WLEN_RESET;
      window_start = '0;
      busy_sum = '0;
      link_sum = '0;
      frame_sum = '0;
      pass_count = '0;
      cpu_peak = '0;
      foreach (svc_calls[i]) begin
        svc_calls[i] = '0;
        svc_worked[i] = '0;
      end
      mismatches = 0;
      windows_closed = 0;
      records_checked = 0;
    endfunction

    // Exact count * 1e6 / span, keeping the low 32 bits.
    function logic [31:0] rate_of(logic [63:0] count, logic [31:0] span);
      logic [63:0] whole, rest, total;
      whole = count / span;
      rest = count % span;
      total = whole * 64'(wurm_pkg::SCALE_US) + (rest * 64'(wurm_pkg::SCALE_US)) / span;
      return total[31:0];
    endfunction

    // Share of the window in percent, clamped at full scale.
    function logic [6:0] percent_of(logic [31:0] sum, logic [31:0] span);
      logic [63:0] share;
      share = (64'(sum) * 64'(wurm_pkg::PCT_SCALE)) / span;
      return (share > 64'(wurm_pkg::PCT_MAX)) ? wurm_pkg::PCT_MAX : share[6:0];
    endfunction

    // A loop pass counts itself, then closes the window if enough time has gone by.
    function void count_pass(logic [31:0] now);
      logic [31:0] span, limit;
      logic [6:0] cpu;
      window_record_t rec;
      pass_count++;
      span = now - window_start;
      limit = (window_len == '0) ? 32'd1 : window_len;
      if (span < limit) return;
      cpu = percent_of(busy_sum, span);
      if (cpu > cpu_peak) cpu_peak = cpu;
      rec = '0;
      rec.cpu = cpu;
      rec.cpu_peak = cpu_peak;
      rec.link = percent_of(link_sum, span);
      rec.fps = rate_of(frame_sum, span);
      rec.pps = rate_of(64'(pass_count), span);
      pending_records.push_back(rec);
      for (int i = 0; i < SERVICES; i++) begin
        rec = '0;
        rec.kind = 1'b1;
        rec.service = i[2:0];
        rec.calls = rate_of(64'(svc_calls[i]), span);
        rec.worked = rate_of(64'(svc_worked[i]), span);
        rec.is_last = (i == SERVICES - 1);
        pending_records.push_back(rec);
        svc_calls[i] = '0;
        svc_worked[i] = '0;
      end
      window_start = now;
      busy_sum = '0;
      link_sum = '0;
      frame_sum = '0;
      pass_count = '0;
      windows_closed++;
    endfunction

    // Apply one accepted input beat to the predicted state.
    function void note_event(logic [2:0] act, logic [31:0] now, logic [31:0] amount,
                             logic [2:0] svc, logic did_work);
      case (act)
        wurm_pkg::ACT_PASS:   count_pass(now);
        wurm_pkg::ACT_BUSY:   busy_sum += amount;
        wurm_pkg::ACT_LINK:   link_sum += amount;
        wurm_pkg::ACT_FRAMES: frame_sum += 64'(amount);
        wurm_pkg::ACT_SVC: begin
          if (svc < SERVICES) begin
            svc_calls[svc]++;
            if (did_work) svc_worked[svc]++;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Compare one output beat with the oldest predicted record.
    function void check_record(window_record_t got);
      window_record_t want;
      if (pending_records.size() == 0) begin
        mismatches++;
        $display("%0t: record kind %0d service %0d expected none, actual one arrived",
                 $time, got.kind, got.service);
        return;
      end
      want = pending_records.pop_front();
      records_checked++;
      compare_field("record_kind", want.kind, got.kind);
      compare_field("record_service", want.service, got.service);
      compare_field("cpu_util", want.cpu, got.cpu);
      compare_field("cpu_util_peak", want.cpu_peak, got.cpu_peak);
      compare_field("link_percent", want.link, got.link);
      compare_field("frames_per_second", want.fps, got.fps);
      compare_field("passes_per_second", want.pps, got.pps);
      compare_field("calls_per_second", want.calls, got.calls);
      compare_field("worked_per_second", want.worked, got.worked);
      compare_field("last", want.is_last, got.is_last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        window_length_we_i;
  logic [31:0] window_length_us_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  logic [31:0] now_us_i;
  logic [31:0] amount_i;
  logic [2:0]  service_index_i;
  logic        did_work_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        record_kind_o;
  logic [2:0]  record_service_o;
  logic [6:0]  cpu_util_o;
  logic [6:0]  cpu_util_peak_o;
  logic [6:0]  link_percent_o;
  logic [31:0] frames_per_second_o;
  logic [31:0] passes_per_second_o;
  logic [31:0] calls_per_second_o;
  logic [31:0] worked_per_second_o;
  logic        last_o;

  utilization_scoreboard board;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beats_sent;
  logic [31:0] now_clock;

  windowed_utilization_rate_monitor #(
    .SERVICE_COUNT(SERVICES)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .window_length_we_i (window_length_we_i),
    .window_length_us_i (window_length_us_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .now_us_i           (now_us_i),
    .amount_i           (amount_i),
    .service_index_i    (service_index_i),
    .did_work_i         (did_work_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .record_kind_o      (record_kind_o),
    .record_service_o   (record_service_o),
    .cpu_util_o         (cpu_util_o),
    .cpu_util_peak_o    (cpu_util_peak_o),
    .link_percent_o     (link_percent_o),
    .frames_per_second_o(frames_per_second_o),
    .passes_per_second_o(passes_per_second_o),
    .calls_per_second_o (calls_per_second_o),
    .worked_per_second_o(worked_per_second_o),
    .last_o             (last_o)
  );

  always #1 clk_i = ~clk_i;

  // The receiver stalls at random according to the current idle share.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every output beat is checked against the oldest predicted record.
  always @(posedge clk_i) begin : record_monitor
    window_record_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.kind = record_kind_o;
      seen.service = record_service_o;
      seen.cpu = cpu_util_o;
      seen.cpu_peak = cpu_util_peak_o;
      seen.link = link_percent_o;
      seen.fps = frames_per_second_o;
      seen.pps = passes_per_second_o;
      seen.calls = calls_per_second_o;
      seen.worked = worked_per_second_o;
      seen.is_last = last_o;
      board.check_record(seen);
    end
  end

  // Present one input beat, with a random gap first, and wait until it is taken.
  task automatic send_event(input logic [2:0] act, input logic [31:0] now,
                            input logic [31:0] amount, input logic [2:0] svc,
                            input logic did_work);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    now_us_i <= now;
    amount_i <= amount;
    service_index_i <= svc;
    did_work_i <= did_work;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_event(act, now, amount, svc, did_work);
    beats_sent++;
  endtask

  // Wait until every predicted record has come out, then a little longer.
  task automatic settle(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (board.pending_records.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_window_length(input logic [31:0] value);
    window_length_we_i <= 1'b1;
    window_length_us_i <= value;
    @(posedge clk_i);
    window_length_we_i <= 1'b0;
    board.window_len = value;
  endtask

  // Random event mix; pass times mostly advance by up to one window length.
  task automatic run_random(input int unsigned beats, input logic [31:0] span_max,
                            input int unsigned close_goal);
    int unsigned useful, sel, first_close;
    logic [2:0] act, svc;
    logic [31:0] now, amount;
    logic did_work;
    useful = 0;
    first_close = board.windows_closed;
    while (useful < beats || board.windows_closed - first_close < close_goal) begin
      sel = $urandom_range(0, 99);
      now = $urandom;
      amount = $urandom;
      svc = $urandom_range(0, 7);
      did_work = $urandom_range(0, 1);
      if (sel < 30) begin
        act = wurm_pkg::ACT_PASS;
        if ($urandom_range(0, 3) != 0) begin
          now_clock = now_clock + $urandom_range(0, span_max);
          now = now_clock;
        end else begin
          now_clock = now;
        end
      end else if (sel < 45) begin
        act = wurm_pkg::ACT_BUSY;
        if ($urandom_range(0, 7) != 0) amount = $urandom_range(0, span_max >> 2);
      end else if (sel < 55) begin
        act = wurm_pkg::ACT_LINK;
        if ($urandom_range(0, 7) != 0) amount = $urandom_range(0, span_max >> 2);
      end else if (sel < 65) begin
        act = wurm_pkg::ACT_FRAMES;
        if ($urandom_range(0, 7) != 0) amount = $urandom_range(0, 300);
      end else if (sel < 95) begin
        act = wurm_pkg::ACT_SVC;
      end else begin
        act = $urandom_range(ACT_SPARE_LO, ACT_SPARE_HI);
      end
      send_event(act, now, amount, svc, did_work);
      if (act <= wurm_pkg::ACT_SVC && !(act == wurm_pkg::ACT_SVC && svc >= SERVICES)) useful++;
    end
  endtask

  initial begin
    logic [31:0] len;
    board = new();
    beats_sent = 0;
    now_clock = '0;
    send_idle_pct = 16;
    recv_idle_pct = 54;
    rst_ni <= 1'b0;
    window_length_we_i <= 1'b0;
    window_length_us_i <= '0;
    in_valid_i <= 1'b0;
    action_i <= wurm_pkg::ACT_PASS;
    now_us_i <= '0;
    amount_i <= '0;
    service_index_i <= '0;
    did_work_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero window length behaves as one: sums wrap, frames go past 32 bits.
    set_window_length('0);
    send_event(wurm_pkg::ACT_BUSY, '0, 32'hFFFF_FFFF, '0, 1'b0);
    send_event(wurm_pkg::ACT_BUSY, '0, 32'd5, '0, 1'b0);
    send_event(wurm_pkg::ACT_LINK, '0, 32'hFFFF_FFFF, '0, 1'b0);
    send_event(wurm_pkg::ACT_FRAMES, '0, 32'hFFFF_FFFF, '0, 1'b0);
    send_event(wurm_pkg::ACT_FRAMES, '0, 32'hFFFF_FFFF, '0, 1'b0);
    send_event(wurm_pkg::ACT_SVC, '0, '0, 3'd0, 1'b1);
    send_event(wurm_pkg::ACT_SVC, '0, '0, 3'd5, 1'b0);
    send_event(wurm_pkg::ACT_SVC, '0, '0, 3'd6, 1'b1);
    send_event(wurm_pkg::ACT_SVC, '0, '0, 3'd7, 1'b1);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
      send_event(a[2:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1);
    end
    send_event(wurm_pkg::ACT_PASS, '0, '0, '0, 1'b0);
    send_event(wurm_pkg::ACT_PASS, 32'd1, '0, '0, 1'b0);
    settle(IDLE_SETTLE);

    // Longest possible window: closes only at the full wrapping distance.
    set_window_length(32'hFFFF_FFFF);
    send_event(wurm_pkg::ACT_SVC, '0, '0, 3'd3, 1'b1);
    send_event(wurm_pkg::ACT_PASS, '0, '0, '0, 1'b0);
    settle(IDLE_SETTLE);

    // Shortest window: clamped percentages and a wrapped elapsed time.
    set_window_length(32'd1);
    send_event(wurm_pkg::ACT_BUSY, '0, 32'd3, '0, 1'b0);
    send_event(wurm_pkg::ACT_LINK, '0, 32'd1, '0, 1'b0);
    send_event(wurm_pkg::ACT_PASS, 32'd2, '0, '0, 1'b0);
    send_event(wurm_pkg::ACT_PASS, 32'd2, '0, '0, 1'b0);
    send_event(wurm_pkg::ACT_PASS, 32'd1, '0, '0, 1'b0);
    settle(IDLE_SETTLE);
    now_clock = 32'd1;

    // Short windows, slow receiver.
    len = $urandom_range(1, 4000);
    set_window_length(len);
    run_random(40, len, 2);
    settle(IDLE_SETTLE);

    // Medium windows, slow sender.
    send_idle_pct = 54;
    recv_idle_pct = 16;
    len = $urandom_range(4000, 2000000);
    set_window_length(len);
    run_random(40, len, 2);
    settle(IDLE_SETTLE);

    // Any window length at full throughput.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    len = $urandom;
    set_window_length(len);
    run_random(40, len, 6);
    settle(CLOSE_SETTLE);

    $display("Sent %0d input beats; checked %0d records from %0d window closes.",
             beats_sent, board.records_checked, board.windows_closed);
    $display("Window lengths: zero, one, all ones, and three random settings.");
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("Timed out with %0d records outstanding.", board.pending_records.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
